// ===== hdl/trle_pkg.sv =====
// Package for the trie Levenshtein row engine: sizes, command and state types, helpers.
`timescale 1ns / 1ps
package trle_pkg;

   localparam int MAX_LEN = 32;
   localparam int ROWS    = MAX_LEN + 1;
   localparam int COL_W   = $clog2(ROWS);
   localparam int CHAR_AW = $clog2(MAX_LEN);
   localparam int ROW_AW  = $clog2(ROWS * ROWS);
   localparam int DIST_W  = 6;
   // per-depth entry: exact flag, mismatch count, highest row column written
   localparam int PATH_W  = 1 + DIST_W + COL_W;

   localparam logic [DIST_W-1:0] ROW_SAT = 6'd63;
   localparam logic [2:0]        MAX_DISTANCE_RESET = 3'd3;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_VISIT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [COL_W-1:0]  index;   // load position or visit depth
      logic [7:0]        letter;
      logic              last;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } back_state_type;

   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      return (v == ROW_SAT) ? ROW_SAT : v + 1'b1;
   endfunction

   function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                              input logic [DIST_W-1:0] b,
                                              input logic [DIST_W-1:0] c);
      logic [DIST_W-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

endpackage

// ===== hdl/trle_ram.sv =====
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module trle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/trle_front.sv =====
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module trle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [4:0]        req_position,
   input  logic [7:0]        req_letter,
   input  logic [5:0]        req_depth,
   input  logic              req_is_last,
   output logic              q_valid,
   output trle_pkg::cmd_type q_cmd,
   input  logic              q_pop
);
   import trle_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd;
   logic       push;

   always_comb begin
      cmd.letter = req_letter;
      cmd.last   = req_is_last;
      if (!req_opcode) begin
         cmd.index = COL_W'(req_position);
         cmd.kind  = (32'(req_position) < MAX_LEN) ? CMD_LOAD : CMD_NOP;
      end else begin
         cmd.index = COL_W'(req_depth);
         cmd.kind  = (req_depth != '0 && 32'(req_depth) <= MAX_LEN) ? CMD_VISIT : CMD_NOP;
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule

// ===== hdl/trle_back.sv =====
// Back end: runs loads and the column sweep of each visit, holds the result register.
`timescale 1ns / 1ps
module trle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_data,
   input  logic              q_valid,
   input  trle_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [5:0]        rsp_final_distance,
   output logic [5:0]        rsp_row_minimum,
   output logic [5:0]        rsp_hamming_count,
   output logic              rsp_exact_match,
   output logic              rsp_keep_descending
);
   import trle_pkg::*;

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  dep_ff, dep_in;
   logic [7:0]        letter_ff, letter_in;
   logic [COL_W-1:0]  len_ff, len_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [DIST_W-1:0] prev_last_ff, prev_last_in;
   logic [DIST_W-1:0] cur_last_ff, cur_last_in;
   logic [DIST_W-1:0] min_ff, min_in;
   logic              match_ff, match_in;
   logic [DIST_W-1:0] cnt_prev_ff, cnt_prev_in;
   logic              exact_prev_ff, exact_prev_in;
   logic [COL_W-1:0]  hi_prev_ff, hi_prev_in;
   logic [ROWS-1:0]   valid_ff, valid_in;
   logic [2:0]        maxd_ff, maxd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        edit_ff, edit_in;
   logic [5:0]        rmin_ff, rmin_in;
   logic [5:0]        ham_ff, ham_in;
   logic              exact_ff, exact_in;
   logic              keep_ff, keep_in;

   logic [COL_W-1:0]  rd_col, rd_dep, parent;
   logic [COL_W-1:0]  path_rd_addr, hi_old, hi_new;
   logic [ROW_AW-1:0] row_rd_addr, row_wr_addr;
   logic [DIST_W-1:0] row_rd_data, row_wr_data;
   logic              row_wr_en;
   logic [CHAR_AW-1:0] char_rd_addr, char_wr_addr;
   logic [7:0]        char_rd_data;
   logic              char_wr_en;
   logic [PATH_W-1:0] path_rd_data, path_wr_data;
   logic              path_wr_en;
   logic [DIST_W-1:0] prev_c, cur, ins, del, rep, col_sat, cnt_new;
   logic              parent_valid, exact_new;

   assign parent       = dep_ff - 1'b1;
   assign parent_valid = valid_ff[parent];
   assign rd_col       = (state_ff == ST_IDLE) ? '0 : col_ff + 1'b1;
   assign rd_dep       = (state_ff == ST_IDLE) ? q_cmd.index - 1'b1 : parent;
   // parent's entry is read for the sweep, then this depth's own entry for the finish
   assign path_rd_addr = (state_ff == ST_IDLE) ? q_cmd.index - 1'b1 : dep_ff;
   assign row_rd_addr  = ROW_AW'(rd_dep) * ROW_AW'(ROWS) + ROW_AW'(rd_col);
   assign row_wr_addr  = ROW_AW'(dep_ff) * ROW_AW'(ROWS) + ROW_AW'(col_ff);
   assign char_rd_addr = CHAR_AW'(rd_col - 1'b1);
   assign char_wr_addr = CHAR_AW'(q_cmd.index);

   trle_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_char_ram (
      .clock(clock), .wr_en(char_wr_en), .wr_addr(char_wr_addr),
      .wr_data(q_cmd.letter), .rd_addr(char_rd_addr), .rd_data(char_rd_data)
   );

   trle_ram #(.WIDTH(DIST_W), .DEPTH(ROWS * ROWS)) u_row_ram (
      .clock(clock), .wr_en(row_wr_en), .wr_addr(row_wr_addr),
      .wr_data(row_wr_data), .rd_addr(row_rd_addr), .rd_data(row_rd_data)
   );

   trle_ram #(.WIDTH(PATH_W), .DEPTH(ROWS)) u_path_ram (
      .clock(clock), .wr_en(path_wr_en), .wr_addr(dep_ff),
      .wr_data(path_wr_data), .rd_addr(path_rd_addr), .rd_data(path_rd_data)
   );

   // Columns past a row's highest written one read as reset: row zero is its
   // column index, others zero.
   always_comb begin
      col_sat = (32'(col_ff) > 32'(ROW_SAT)) ? ROW_SAT : DIST_W'(col_ff);
      if (parent_valid && (col_ff == '0 || col_ff <= hi_prev_ff)) prev_c = row_rd_data;
      else if (parent == '0) prev_c = col_sat;
      else prev_c = '0;
      ins = sat_inc(cur_last_ff);
      del = sat_inc(prev_c);
      rep = (char_rd_data != letter_ff) ? sat_inc(prev_last_ff) : prev_last_ff;
      cur = (col_ff == '0) ? sat_inc(prev_c) : min3(ins, del, rep);
      cnt_new = (!match_ff && cnt_prev_ff <= DIST_W'(maxd_ff)) ? cnt_prev_ff + 1'b1
                                                                : cnt_prev_ff;
      exact_new = exact_prev_ff && match_ff;
      hi_old = valid_ff[dep_ff] ? path_rd_data[COL_W-1:0] : '0;
      hi_new = (hi_old > len_ff) ? hi_old : len_ff;
   end

   always_comb begin
      state_in      = state_ff;
      dep_in        = dep_ff;
      letter_in     = letter_ff;
      len_in        = len_ff;
      col_in        = col_ff;
      prev_last_in  = prev_last_ff;
      cur_last_in   = cur_last_ff;
      min_in        = min_ff;
      match_in      = match_ff;
      cnt_prev_in   = cnt_prev_ff;
      exact_prev_in = exact_prev_ff;
      hi_prev_in    = hi_prev_ff;
      valid_in      = valid_ff;
      maxd_in       = csr_wr_en ? csr_wr_data : maxd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      edit_in       = edit_ff;
      rmin_in       = rmin_ff;
      ham_in        = ham_ff;
      exact_in      = exact_ff;
      keep_in       = keep_ff;
      q_pop         = 1'b0;
      char_wr_en    = 1'b0;
      row_wr_en     = 1'b0;
      row_wr_data   = cur;
      path_wr_en    = 1'b0;
      path_wr_data  = {exact_new, cnt_new, hi_new};

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  CMD_VISIT: begin
                     dep_in    = q_cmd.index;
                     letter_in = q_cmd.letter;
                     col_in    = '0;
                     match_in  = 1'b0;
                     state_in  = ST_SWEEP;
                  end
                  CMD_LOAD: begin
                     char_wr_en = 1'b1;
                     if (q_cmd.last) len_in = q_cmd.index + 1'b1;
                     rsp_valid_in = 1'b1;
                     {edit_in, rmin_in, ham_in, exact_in, keep_in} = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     {edit_in, rmin_in, ham_in, exact_in, keep_in} = '0;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            row_wr_en    = 1'b1;
            prev_last_in = prev_c;
            cur_last_in  = cur;
            min_in       = (col_ff == '0 || cur < min_ff) ? cur : min_ff;
            if (col_ff != '0 && col_ff == dep_ff) match_in = (char_rd_data == letter_ff);
            if (col_ff == '0) begin
               cnt_prev_in   = parent_valid ? path_rd_data[COL_W +: DIST_W] : '0;
               exact_prev_in = parent_valid ? path_rd_data[PATH_W-1] : 1'b1;
               hi_prev_in    = parent_valid ? path_rd_data[COL_W-1:0] : '0;
            end
            if (col_ff == len_ff) state_in = ST_FINISH;
            else col_in = col_ff + 1'b1;
         end
         ST_FINISH: begin
            path_wr_en       = 1'b1;
            valid_in[dep_ff] = 1'b1;
            rsp_valid_in     = 1'b1;
            edit_in          = cur_last_ff;
            rmin_in          = min_ff;
            ham_in           = cnt_new;
            exact_in         = exact_new;
            keep_in          = (min_ff < DIST_W'(maxd_ff));
            state_in         = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         valid_ff     <= '0;
         maxd_ff      <= MAX_DISTANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         valid_ff     <= valid_in;
         maxd_ff      <= maxd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dep_ff        <= dep_in;
      letter_ff     <= letter_in;
      col_ff        <= col_in;
      prev_last_ff  <= prev_last_in;
      cur_last_ff   <= cur_last_in;
      min_ff        <= min_in;
      match_ff      <= match_in;
      cnt_prev_ff   <= cnt_prev_in;
      exact_prev_ff <= exact_prev_in;
      hi_prev_ff    <= hi_prev_in;
      edit_ff       <= edit_in;
      rmin_ff       <= rmin_in;
      ham_ff        <= ham_in;
      exact_ff      <= exact_in;
      keep_ff       <= keep_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_final_distance  = edit_ff;
   assign rsp_row_minimum     = rmin_ff;
   assign rsp_hamming_count   = ham_ff;
   assign rsp_exact_match     = exact_ff;
   assign rsp_keep_descending = keep_ff;
endmodule

// ===== hdl/trie_levenshtein_row_engine.sv =====
// Top level of the trie Levenshtein row engine.
// Usage:
//  - req_* channel (valid/ready): opcode 0 loads one word character at position;
//    is_last sets the word length. Opcode 1 visits a trie
//    node at depth with letter and builds that depth's row from depth-1.
//  - rsp_* channel (valid/ready): exactly one result per request, in order.
//    Loads and out-of-range requests return all-zero fields.
//  - csr_wr_en/csr_wr_data write max_distance (reset value 3) while idle.
// Timing:
//  - A visit sweeps columns 0..word length through the row memory, one column a
//    cycle, after a read of column zero issued as it leaves the queue; a finish
//    state then loads the result register. A load writes it directly from idle.
//  - Items are worked one at a time; the next leaves the queue the cycle after a
//    result is taken.
//    A two-entry queue in front lets requests be taken while the back end sweeps.
// Reset clears word length, per-depth valid bits and the queue; no memory pass
// is needed, so requests are taken in the first cycle after reset.
// A stalled rsp_ready holds the result register; the back end then waits and
// the queue fills, after which req_ready drops.
`timescale 1ns / 1ps
module trie_levenshtein_row_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [4:0] req_position,
   input  logic [7:0] req_letter,
   input  logic [5:0] req_depth,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_final_distance,
   output logic [5:0] rsp_row_minimum,
   output logic [5:0] rsp_hamming_count,
   output logic       rsp_exact_match,
   output logic       rsp_keep_descending,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);
   import trle_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   trle_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_position(req_position),
      .req_letter(req_letter), .req_depth(req_depth), .req_is_last(req_is_last),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
   );

   trle_back u_back (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_final_distance(rsp_final_distance), .rsp_row_minimum(rsp_row_minimum),
      .rsp_hamming_count(rsp_hamming_count), .rsp_exact_match(rsp_exact_match),
      .rsp_keep_descending(rsp_keep_descending)
   );
endmodule
